/* sv/dfcc_pkg.sv */
// shared types and constants of the dmx fixture channel capture unit
package dfcc_pkg;

    // widths fixed by the field definitions
    localparam int BYTE_W     = 8;
    localparam int START_W    = 9;
    localparam int TALLY_W    = 6;
    localparam int GAMMA_DEPTH = 256;
    localparam int LANES      = 4;

    // parameter defaults
    localparam int UNIVERSE_SLOTS_DEF    = 512;
    localparam int LED_TOGGLE_FRAMES_DEF = 50;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    // fixed output when the start address is zero
    localparam logic [BYTE_W-1:0] DFLT_RED   = 8'hA0;
    localparam logic [BYTE_W-1:0] DFLT_GREEN = 8'h20;
    localparam logic [BYTE_W-1:0] DFLT_BLUE  = 8'h00;
    localparam logic [BYTE_W-1:0] DFLT_WHITE = 8'hA0;

    typedef enum logic [1:0] {
        FUNC_SLOT  = 2'd0,
        FUNC_BREAK = 2'd1,
        FUNC_TABLE = 2'd2
    } t_func;

    typedef logic [BYTE_W-1:0] t_byte;

endpackage

/* sv/dfcc_if.sv */
// request channels of the dmx fixture channel capture unit

interface dfcc_in_if;
    logic                   valid;
    logic                   ready;
    dfcc_pkg::t_func        func;
    logic [7:0]             data_byte;
    logic [7:0]             table_index;

    modport source (output valid, output func, output data_byte, output table_index,
                    input ready);
    modport sink   (input valid, input func, input data_byte, input table_index,
                    output ready);
endinterface

interface dfcc_out_if;
    logic                   valid;
    logic                   ready;
    logic [7:0]             red_level;
    logic [7:0]             green_level;
    logic [7:0]             blue_level;
    logic [7:0]             white_level;
    logic                   activity_led;

    modport source (output valid, output red_level, output green_level,
                    output blue_level, output white_level, output activity_led,
                    input ready);
    modport sink   (input valid, input red_level, input green_level,
                    input blue_level, input white_level, input activity_led,
                    output ready);
endinterface

/* sv/dfcc_ram.sv */
// generic single write port ram with registered read
module dfcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/dmx_fixture_channel_capture_unit.sv */
// top level of the dmx fixture channel capture unit
//
//  port            dir  handshake        carries
//  i_in            in   valid / ready    func, data_byte, table_index
//  o_out           out  valid / ready    red/green/blue/white_level, activity_led
//  i_cfg_wr_*      in   write enable     start_address (9 bits)
//
//  one request a cycle unless stalled; slot bytes and table writes finish at acceptance
//  a break's result is registered in the gamma ram read, then in the output register
//  four copies of the gamma table give the four lookups of a break in parallel
//  reset (synchronous, active low) clears start address, counter, captured slots, tally,
//  led phase and both result valids; the gamma table is not cleared and has no reset pass
//  an output stall is absorbed by the read stage and the output register; the input
//  stalls only when both hold a result
module dmx_fixture_channel_capture_unit #(
    parameter int UNIVERSE_SLOTS    = dfcc_pkg::UNIVERSE_SLOTS_DEF,
    parameter int LED_TOGGLE_FRAMES = dfcc_pkg::LED_TOGGLE_FRAMES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [dfcc_pkg::START_W-1:0] i_cfg_wr_data,
    dfcc_in_if.sink                      i_in,
    dfcc_out_if.source                   o_out
);
    import dfcc_pkg::*;

    // slot counter must reach the universe size itself (saturation point)
    localparam int CNT_W  = $clog2(UNIVERSE_SLOTS + 1);
    // window offset arithmetic with a borrow bit
    localparam int DIFF_W = ((CNT_W > START_W) ? CNT_W : START_W) + 1;
    localparam int GA_W   = $clog2(GAMMA_DEPTH);

    // configuration
    logic [START_W-1:0] r_start;

    // frame state
    logic [CNT_W-1:0]   r_slot_cnt, n_slot_cnt;
    t_byte              r_cap [LANES];
    t_byte              n_cap [LANES];
    logic [TALLY_W-1:0] r_tally, n_tally;
    logic               r_led, n_led;

    // read stage: ram data is valid while r_s1_valid
    logic               r_s1_valid;
    logic               r_s1_dflt;
    logic               r_s1_led;
    t_byte              w_gamma [LANES];

    // output register
    logic               r_out_valid;
    t_byte              r_out_lvl [LANES];
    logic               r_out_led;

    logic               w_acc, w_slot_acc, w_brk_acc, w_tbl_acc;
    logic               w_in_ready, w_out_adv, w_s1_adv;
    logic [DIFF_W-1:0]  w_diff;
    logic               w_in_win, w_cnt_live, w_wrap;

    // handshake and pipeline advance
    assign w_out_adv  = !r_out_valid || o_out.ready;
    assign w_s1_adv   = r_s1_valid && w_out_adv;
    assign w_in_ready = !r_s1_valid || w_out_adv;
    assign i_in.ready = w_in_ready;

    assign w_acc      = i_in.valid && w_in_ready;
    assign w_slot_acc = w_acc && (i_in.func == FUNC_SLOT);
    assign w_brk_acc  = w_acc && (i_in.func == FUNC_BREAK);
    assign w_tbl_acc  = w_acc && (i_in.func == FUNC_TABLE);

    // capture window: start <= count <= start + 3
    assign w_cnt_live = r_slot_cnt < CNT_W'(UNIVERSE_SLOTS);
    assign w_diff     = DIFF_W'(r_slot_cnt) - DIFF_W'(r_start);
    assign w_in_win   = !w_diff[DIFF_W-1] && (w_diff[DIFF_W-2:2] == '0);

    // led toggles when the tally passes the toggle count or hits its ceiling
    assign w_wrap = (r_tally > TALLY_W'(LED_TOGGLE_FRAMES)) || (r_tally == TALLY_MAX);

    always_comb begin
        n_slot_cnt = r_slot_cnt;
        n_tally    = r_tally;
        n_led      = r_led;
        for (int k = 0; k < LANES; k++) begin
            n_cap[k] = r_cap[k];
        end
        case (i_in.func)
            FUNC_SLOT: begin
                if (w_slot_acc && w_cnt_live) begin
                    if (w_in_win) begin
                        n_cap[w_diff[1:0]] = i_in.data_byte;
                    end
                    n_slot_cnt = r_slot_cnt + CNT_W'(1);
                end
            end
            FUNC_BREAK: begin
                if (w_brk_acc) begin
                    n_slot_cnt = '0;
                    if (w_wrap) begin
                        n_led   = !r_led;
                        n_tally = TALLY_W'(1);
                    end else begin
                        n_tally = r_tally + TALLY_W'(1);
                    end
                end
            end
            default: begin
                // table writes go straight to the rams; unused code is dropped
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= '0;
            r_slot_cnt <= '0;
            r_tally    <= '0;
            r_led      <= 1'b0;
            for (int k = 0; k < LANES; k++) begin
                r_cap[k] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_start <= i_cfg_wr_data;
            end
            r_slot_cnt <= n_slot_cnt;
            r_tally    <= n_tally;
            r_led      <= n_led;
            for (int k = 0; k < LANES; k++) begin
                r_cap[k] <= n_cap[k];
            end
        end
    end

    // one gamma table copy per colour; every table write goes to all four
    for (genvar g = 0; g < LANES; g++) begin : g_gamma
        dfcc_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (GAMMA_DEPTH)
        ) u_gamma (
            .i_clk   (i_clk),
            .i_we    (w_tbl_acc),
            .i_waddr (GA_W'(i_in.table_index)),
            .i_wdata (i_in.data_byte),
            .i_re    (w_brk_acc),
            .i_raddr (GA_W'(r_cap[g])),
            .o_rdata (w_gamma[g])
        );
    end

    // read stage control; ram data holds because only a break reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_s1_valid <= w_brk_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_brk_acc) begin
            r_s1_dflt <= (r_start == '0);
            r_s1_led  <= n_led;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_led <= r_s1_led;
            if (r_s1_dflt) begin
                r_out_lvl[0] <= DFLT_RED;
                r_out_lvl[1] <= DFLT_GREEN;
                r_out_lvl[2] <= DFLT_BLUE;
                r_out_lvl[3] <= DFLT_WHITE;
            end else begin
                for (int k = 0; k < LANES; k++) begin
                    r_out_lvl[k] <= w_gamma[k];
                end
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.red_level    = r_out_lvl[0];
    assign o_out.green_level  = r_out_lvl[1];
    assign o_out.blue_level   = r_out_lvl[2];
    assign o_out.white_level  = r_out_lvl[3];
    assign o_out.activity_led = r_out_led;

    // input is held off only when both result stages are occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_ready |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with a free result stage");

    // a break always lands in the read stage
    a_brk_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_brk_acc |=> r_s1_valid)
        else $error("accepted break lost before read stage");

    // read stage result always moves into the output register
    a_s1_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv |=> r_out_valid)
        else $error("result lost between read stage and output");

    // slot counter saturates at the universe size
    a_cnt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot_cnt <= CNT_W'(UNIVERSE_SLOTS))
        else $error("slot counter past universe size");

    // tally never runs beyond one past the toggle count
    a_tally: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_tally} <= (7'(LED_TOGGLE_FRAMES) + 7'd1))
        else $error("frame tally out of range");

endmodule

/* tb/dfcc_level_checker.sv */
// checker: predicts fixture levels from accepted requests and compares the results
`timescale 1ns / 100ps

module dfcc_level_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [dfcc_pkg::START_W-1:0] i_cfg_wr_data,
    dfcc_in_if                           i_req,
    dfcc_out_if                          i_lvl,
    output int                           o_fail_count,
    output int                           o_levels_due
);
    import dfcc_pkg::*;

    typedef struct packed {
        t_byte red;
        t_byte green;
        t_byte blue;
        t_byte white;
        logic  led;
    } t_levels;

    // own copy of the fixture state
    logic [START_W-1:0] start_addr;
    logic [9:0]         slot_ctr;
    t_byte              captured [LANES];
    t_byte              gamma_copy [GAMMA_DEPTH];
    logic [TALLY_W-1:0] tally;
    logic               led;

    t_levels levels_due [$];

    initial begin
        o_fail_count = 0;
        o_levels_due = 0;
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            o_fail_count++;
        end
    endtask

    task automatic advance_fixture(t_func f, t_byte d, t_byte idx);
        int      offset;
        t_levels lv;
        case (f)
            FUNC_SLOT: begin
                if (slot_ctr < UNIVERSE_SLOTS_DEF) begin
                    offset = int'(slot_ctr) - int'(start_addr);
                    if (offset >= 0 && offset < LANES)
                        captured[offset] = d;
                    slot_ctr++;
                end
            end
            FUNC_TABLE: gamma_copy[idx] = d;
            FUNC_BREAK: begin
                slot_ctr = '0;
                if (start_addr == '0) begin
                    lv.red   = DFLT_RED;
                    lv.green = DFLT_GREEN;
                    lv.blue  = DFLT_BLUE;
                    lv.white = DFLT_WHITE;
                end else begin
                    lv.red   = gamma_copy[captured[0]];
                    lv.green = gamma_copy[captured[1]];
                    lv.blue  = gamma_copy[captured[2]];
                    lv.white = gamma_copy[captured[3]];
                end
                if (tally > LED_TOGGLE_FRAMES_DEF || tally == TALLY_MAX) begin
                    led   = ~led;
                    tally = '0;
                end
                tally    = tally + 1'b1;
                lv.led   = led;
                levels_due.push_back(lv);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_levels want;
        if (!i_rst_n) begin
            start_addr = '0;
            slot_ctr   = '0;
            tally      = '0;
            led        = 1'b0;
            foreach (captured[k])
                captured[k] = '0;
            levels_due.delete();
        end else begin
            if (i_cfg_wr_en)
                start_addr = i_cfg_wr_data;
            if (i_lvl.valid && i_lvl.ready) begin
                if (levels_due.size() == 0) begin
                    $error("result with no expectation waiting");
                    o_fail_count++;
                end else begin
                    want = levels_due.pop_front();
                    check_field("red_level", want.red, i_lvl.red_level);
                    check_field("green_level", want.green, i_lvl.green_level);
                    check_field("blue_level", want.blue, i_lvl.blue_level);
                    check_field("white_level", want.white, i_lvl.white_level);
                    check_field("activity_led", want.led, i_lvl.activity_led);
                end
            end
            if (i_req.valid && i_req.ready)
                advance_fixture(i_req.func, i_req.data_byte, i_req.table_index);
        end
        o_levels_due = levels_due.size();
    end

endmodule

/* tb/testbench.sv */
// stimulus, receiver stalls and verdict for the dmx fixture channel capture unit
`timescale 1ns / 100ps

module testbench;
    import dfcc_pkg::*;

    // unused selector value, the block must ignore it
    localparam t_func FUNC_UNUSED = t_func'(2'd3);

    // cycles without any handshake before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // requests in the random part, on top of about 280 directed ones
    localparam int RANDOM_REQUESTS = 750;

    // receiver behaviour, re-chosen whenever the current mode's stretch runs out
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_BLOCKED
    } t_sink_mode;

    logic i_clk;
    logic i_rst_n;
    logic cfg_wr_en;
    logic [START_W-1:0] cfg_wr_data;

    dfcc_in_if  req_ch ();
    dfcc_out_if lvl_ch ();

    int fail_count;
    int levels_due;
    int requests_sent;
    int burst_left;
    int stall_cycles;

    dmx_fixture_channel_capture_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (req_ch),
        .o_out         (lvl_ch)
    );

    dfcc_level_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_ch),
        .i_lvl         (lvl_ch),
        .o_fail_count  (fail_count),
        .o_levels_due  (levels_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver stalls: open stretches, coin flips, sparse acceptance and long blocks
    initial begin : sink_pattern
        t_sink_mode mode;
        int         mode_left;
        mode_left    = 0;
        mode         = SINK_OPEN;
        lvl_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = t_sink_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
                SINK_OPEN:    lvl_ch.ready <= 1'b1;
                SINK_COIN:    lvl_ch.ready <= 1'($urandom_range(0, 1));
                SINK_SPARSE:  lvl_ch.ready <= ($urandom_range(0, 3) == 0);
                SINK_BLOCKED: lvl_ch.ready <= ((mode_left % 24) >= 20);
                default:      lvl_ch.ready <= 1'b1;
            endcase
        end
    end

    // watchdog: any handshake restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (lvl_ch.valid && lvl_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // one request; the sender works in bursts with random gaps between them
    task automatic put_request(t_func f, t_byte d, t_byte idx);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                req_ch.valid <= 1'b0;
            end
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
        end
        @(negedge i_clk);
        req_ch.valid       <= 1'b1;
        req_ch.func        <= f;
        req_ch.data_byte   <= d;
        req_ch.table_index <= idx;
        do @(posedge i_clk); while (!req_ch.ready);
        burst_left--;
        if (f != FUNC_UNUSED)
            requests_sent++;
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
    endtask

    // register writes only once every break result has come out
    task automatic write_start_address(logic [START_W-1:0] addr);
        idle_input();
        do @(negedge i_clk); while (levels_due != 0);
        // let the two-stage result pipe settle
        repeat (3) @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= addr;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // a break closes the previous frame, then the start code and slot bytes follow;
    // table rewrites and ignored selectors are scattered in between
    task automatic play_frame(int slots);
        put_request(FUNC_BREAK, 8'($urandom), 8'($urandom));
        for (int s = 0; s < slots; s++) begin
            if ($urandom_range(0, 15) == 0)
                put_request(FUNC_TABLE, 8'($urandom), 8'($urandom));
            if ($urandom_range(0, 31) == 0)
                put_request(FUNC_UNUSED, 8'($urandom), 8'($urandom));
            put_request(FUNC_SLOT, 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin : stimulus
        int addr;
        int frames;
        int slots;
        int phase;
        int random_base;

        // every input known from time zero
        i_rst_n            = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        req_ch.valid       = 1'b0;
        req_ch.func        = FUNC_SLOT;
        req_ch.data_byte   = '0;
        req_ch.table_index = '0;
        requests_sent      = 0;
        burst_left         = 0;
        stall_cycles       = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // start address zero: fixed defaults, no table lookup yet
        write_start_address('0);
        put_request(FUNC_BREAK, 8'h00, 8'h00);
        put_request(FUNC_SLOT, 8'h00, 8'h00);
        put_request(FUNC_SLOT, 8'hFF, 8'hFF);
        put_request(FUNC_SLOT, 8'h55, 8'h00);
        put_request(FUNC_SLOT, 8'hAA, 8'h00);
        put_request(FUNC_SLOT, 8'h0F, 8'h00);
        put_request(FUNC_UNUSED, 8'hFF, 8'hFF);
        put_request(FUNC_TABLE, 8'h00, 8'hFF);
        put_request(FUNC_TABLE, 8'hFF, 8'h00);
        put_request(FUNC_BREAK, 8'hFF, 8'hFF);

        // fill the whole gamma table so that no lookup can hit an unwritten entry
        for (int e = 0; e < GAMMA_DEPTH; e++)
            put_request(FUNC_TABLE, 8'($urandom), 8'(e));

        // start address one: slots kept from the frame above go through the table
        write_start_address(9'd1);
        put_request(FUNC_BREAK, 8'h00, 8'h00);
        put_request(FUNC_SLOT, 8'h00, 8'h00);
        put_request(FUNC_SLOT, 8'hFF, 8'h00);
        put_request(FUNC_SLOT, 8'h00, 8'h00);
        put_request(FUNC_SLOT, 8'h80, 8'h00);
        put_request(FUNC_SLOT, 8'h7F, 8'h00);
        put_request(FUNC_BREAK, 8'h00, 8'h00);
        // short frame: the three missing slots keep their old values
        put_request(FUNC_SLOT, 8'h00, 8'h00);
        put_request(FUNC_SLOT, 8'h01, 8'h00);
        put_request(FUNC_BREAK, 8'h00, 8'h00);

        // random phases: the first runs at the top of the universe, so the window
        // hangs past the last slot and the counter saturates; then address zero,
        // then mostly small addresses with well-formed frames
        random_base = requests_sent;
        phase       = 0;
        while (requests_sent - random_base < RANDOM_REQUESTS) begin
            if (phase == 0)
                addr = 511;
            else if (phase == 1 || $urandom_range(0, 5) == 0)
                addr = 0;
            else if ($urandom_range(0, 4) == 0)
                addr = $urandom_range(17, 60);
            else
                addr = $urandom_range(1, 16);
            write_start_address(START_W'(addr));
            frames = (addr >= 256) ? 3 : $urandom_range(3, 10);
            for (int f = 0; f < frames; f++) begin
                if (addr >= 256)
                    slots = (f == 0) ? UNIVERSE_SLOTS_DEF + $urandom_range(0, 4)
                                     : $urandom_range(0, 8);
                else if ($urandom_range(0, 3) != 0)
                    slots = addr + LANES + $urandom_range(0, 3);
                else
                    slots = $urandom_range(0, addr + LANES);
                play_frame(slots);
            end
            put_request(FUNC_BREAK, 8'($urandom), 8'($urandom));
            phase++;
        end

        // drain: wait for every outstanding result before the verdict
        idle_input();
        do @(negedge i_clk); while (levels_due != 0);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
